/* rtl/gmd_pkg.sv */
// Package for the grid maze DFS generator: grid constants, FSM states,
// visited-map port struct and neighbor helper. No dependencies.
`default_nettype none
package gmd_pkg;
   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int XW         = $clog2(MAX_COLS);
   localparam int YW         = $clog2(MAX_ROWS);
   localparam int AW         = XW + YW;
   localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
   localparam int SPW        = AW + 1;
   localparam int DIMW       = 6;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLEAR,
      S_CHECK,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic          we;
      logic [AW-1:0] waddr;
      logic          wdata;
      logic [AW-1:0] raddr;
   } vis_req_type;

   function automatic logic [AW-1:0] neighbor_addr(input logic [XW-1:0] x,
                                                   input logic [YW-1:0] y,
                                                   input logic [1:0] d);
      logic [XW-1:0] nx;
      logic [YW-1:0] ny;
      nx = x;
      ny = y;
      case (d)
         DIR_RIGHT: nx = x + XW'(1);
         DIR_UP:    ny = y + YW'(1);
         DIR_LEFT:  nx = x - XW'(1);
         default:   ny = y - YW'(1);
      endcase
      return {ny, nx};
   endfunction
endpackage
`default_nettype wire

/* rtl/gmd_visit_map.sv */
// Visited map: one bit per cell, synchronous read: data comes the cycle after the address.
// Depends on gmd_pkg.
`default_nettype none
module gmd_visit_map (
   input  wire logic              clock,
   input  wire gmd_pkg::vis_req_type req,
   output logic                   rdata
);
   logic mem [gmd_pkg::CELL_TOTAL];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata <= mem[req.raddr];
   end
endmodule
`default_nettype wire

/* rtl/grid_maze_dfs_generator.sv */
// Top level of the grid maze DFS generator: control FSM, cell stack memory,
// size registers. Depends on gmd_pkg and gmd_visit_map.
//
// channel  direction  signals
// req      in         start, busy, req_start_req, req_rand_dir
// rsp      out        rsp_valid, rsp_from_x, rsp_from_y, rsp_carve_dir, rsp_done_res
// csr      in         csr_valid, csr_ready, csr_index, csr_data
//
// A start request sweeps all 1024 cells of the visited map with busy high.
// A direction request holds busy for each neighbor check pass (one visited
// read per direction, then a decide step), plus a stack read and a new pass
// per backtrack pop. Each request also spends its accept cycle in idle.
// Reset is synchronous and clears control state; the map is cleared by start.
// The result shows for one cycle after the item ends; the receiver cannot stall.
`default_nettype none
module grid_maze_dfs_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_start_req,
   input  wire logic [1:0]  req_rand_dir,
   output logic             rsp_valid,
   output logic [4:0]       rsp_from_x,
   output logic [4:0]       rsp_from_y,
   output logic [1:0]       rsp_carve_dir,
   output logic             rsp_done_res,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_data
);
   localparam int XW   = gmd_pkg::XW;
   localparam int YW   = gmd_pkg::YW;
   localparam int AW   = gmd_pkg::AW;
   localparam int SPW  = gmd_pkg::SPW;
   localparam int DIMW = gmd_pkg::DIMW;

   gmd_pkg::state_type state_ff, state_in;
   logic [DIMW-1:0] rows_ff, cols_ff;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [SPW-1:0]  sp_ff, sp_in;
   logic [XW-1:0]   cx_ff, cx_in;
   logic [YW-1:0]   cy_ff, cy_in;
   logic [SPW-1:0]  vc_ff, vc_in;
   logic            fin_ff, fin_in;
   logic [1:0]      dir_ff, dir_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            pend_ff, pend_in;
   logic [1:0]      pdir_ff, pdir_in;
   logic            pinb_ff, pinb_in;
   logic [3:0]      open_ff, open_in;
   logic            ov_ff, ov_in;
   logic [XW-1:0]   ox_ff, ox_in;
   logic [YW-1:0]   oy_ff, oy_in;
   logic [1:0]      od_ff, od_in;
   logic            odn_ff, odn_in;

   logic [DIMW-1:0] rows, cols;
   logic [SPW-1:0]  total;
   logic            accept;
   logic            inb;
   logic [3:0]      mask_now;
   logic            vis_rd;
   gmd_pkg::vis_req_type vreq;
   logic            stk_we;
   logic [AW-1:0]   stk_waddr, stk_raddr, stk_rd;
   logic [AW-1:0]   carve_addr;
   logic [SPW-1:0]  sp_dec;

   logic [AW-1:0] stack_mem [gmd_pkg::CELL_TOTAL];

   gmd_visit_map u_visit (
      .clock (clock),
      .req   (vreq),
      .rdata (vis_rd)
   );

   always_comb begin
      rows = rows_ff;
      if (rows_ff < DIMW'(2)) rows = DIMW'(2);
      else if (rows_ff > DIMW'(gmd_pkg::MAX_ROWS)) rows = DIMW'(gmd_pkg::MAX_ROWS);
      cols = cols_ff;
      if (cols_ff < DIMW'(2)) cols = DIMW'(2);
      else if (cols_ff > DIMW'(gmd_pkg::MAX_COLS)) cols = DIMW'(gmd_pkg::MAX_COLS);
   end

   assign total     = SPW'(rows) * SPW'(cols);
   assign busy      = (state_ff != gmd_pkg::S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign sp_dec    = sp_ff - SPW'(1);

   always_comb begin
      case (cnt_ff[1:0])
         gmd_pkg::DIR_RIGHT: inb = ({1'b0, cx_ff} + DIMW'(1)) < cols;
         gmd_pkg::DIR_UP:    inb = ({1'b0, cy_ff} + DIMW'(1)) < rows;
         gmd_pkg::DIR_LEFT:  inb = (cx_ff != '0);
         default:            inb = (cy_ff != '0);
      endcase
      mask_now = open_ff;
      if (pend_ff && pinb_ff && !vis_rd) begin
         mask_now[pdir_ff] = 1'b1;
      end
   end

   assign carve_addr = gmd_pkg::neighbor_addr(cx_ff, cy_ff, dir_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmd_pkg::S_IDLE: begin
            if (accept) begin
               if (req_start_req) state_in = gmd_pkg::S_CLEAR;
               else if (vc_ff != '0 && !fin_ff && vc_ff < total) state_in = gmd_pkg::S_CHECK;
            end
         end
         gmd_pkg::S_CLEAR: begin
            if (clr_ff == '0) state_in = gmd_pkg::S_IDLE;
         end
         gmd_pkg::S_CHECK: begin
            if (cnt_ff[2]) begin
               if (mask_now == '0 && sp_ff != '0 && sp_dec != '0) state_in = gmd_pkg::S_LOAD;
               else state_in = gmd_pkg::S_IDLE;
            end
         end
         gmd_pkg::S_LOAD: state_in = gmd_pkg::S_CHECK;
         default: state_in = gmd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      clr_in  = clr_ff;
      sp_in   = sp_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      vc_in   = vc_ff;
      fin_in  = fin_ff;
      dir_in  = dir_ff;
      cnt_in  = cnt_ff;
      pend_in = 1'b0;
      pdir_in = cnt_ff[1:0];
      pinb_in = inb;
      open_in = open_ff;
      ov_in   = 1'b0;
      ox_in   = cx_ff;
      oy_in   = cy_ff;
      od_in   = dir_ff;
      odn_in  = 1'b0;
      vreq.we    = 1'b0;
      vreq.waddr = clr_ff;
      vreq.wdata = 1'b0;
      vreq.raddr = gmd_pkg::neighbor_addr(cx_ff, cy_ff, cnt_ff[1:0]);
      stk_we    = 1'b0;
      stk_waddr = sp_ff[AW-1:0];
      stk_raddr = AW'(sp_ff - SPW'(2));
      case (state_ff)
         gmd_pkg::S_IDLE: begin
            if (accept) begin
               dir_in  = req_rand_dir;
               cnt_in  = '0;
               open_in = '0;
               if (req_start_req) begin
                  clr_in = '1;
               end else if (vc_ff != '0 && !fin_ff && vc_ff >= total) begin
                  fin_in = 1'b1;
               end
            end
         end
         gmd_pkg::S_CLEAR: begin
            vreq.we    = 1'b1;
            vreq.wdata = (clr_ff == '0);
            clr_in     = clr_ff - AW'(1);
            if (clr_ff == '0) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               sp_in     = SPW'(1);
               cx_in     = '0;
               cy_in     = '0;
               vc_in     = SPW'(1);
               fin_in    = 1'b0;
            end
         end
         gmd_pkg::S_CHECK: begin
            pend_in = !cnt_ff[2];
            open_in = mask_now;
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff[2]) begin
               if (mask_now == '0) begin
                  if (sp_ff != '0) sp_in = sp_dec;
               end else if (mask_now[dir_ff]) begin
                  vreq.we    = 1'b1;
                  vreq.waddr = carve_addr;
                  vreq.wdata = 1'b1;
                  if (!sp_ff[AW]) begin
                     stk_we    = 1'b1;
                     stk_waddr = sp_ff[AW-1:0];
                     stk_waddr = sp_ff[AW-1:0];
                     sp_in     = sp_ff + SPW'(1);
                  end
                  stk_waddr = sp_ff[AW-1:0];
                  cx_in  = carve_addr[XW-1:0];
                  cy_in  = carve_addr[AW-1:XW];
                  vc_in  = vc_ff + SPW'(1);
                  fin_in = (vc_ff + SPW'(1)) >= total;
                  ov_in  = 1'b1;
                  odn_in = (vc_ff + SPW'(1)) >= total;
               end
            end
         end
         gmd_pkg::S_LOAD: begin
            cx_in   = stk_rd[XW-1:0];
            cy_in   = stk_rd[AW-1:XW];
            cnt_in  = '0;
            open_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= carve_addr & {AW{state_ff == gmd_pkg::S_CHECK}};
      end
      stk_rd <= stack_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmd_pkg::S_IDLE;
         rows_ff  <= DIMW'(8);
         cols_ff  <= DIMW'(8);
         sp_ff    <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         vc_ff    <= '0;
         fin_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         vc_ff    <= vc_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == gmd_pkg::REG_ROWS) rows_ff <= csr_data;
            else if (csr_index == gmd_pkg::REG_COLS) cols_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      clr_ff  <= clr_in;
      dir_ff  <= dir_in;
      cnt_ff  <= cnt_in;
      pdir_ff <= pdir_in;
      pinb_ff <= pinb_in;
      open_ff <= open_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      od_ff   <= od_in;
      odn_ff  <= odn_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_from_x    = ox_ff;
   assign rsp_from_y    = oy_ff;
   assign rsp_carve_dir = od_ff;
   assign rsp_done_res  = odn_ff;
endmodule
`default_nettype wire

/* tb/sv/grid_maze_dfs_checker.sv */
// Checker for grid_maze_dfs_generator: watches the request, result and CSR
// channels, predicts each carve event and compares it field by field.
// Depends on gmd_pkg for grid sizes and direction codes.
`timescale 1ns / 100ps
module grid_maze_dfs_checker
   import gmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_start_req,
   input  logic [1:0] req_rand_dir,
   input  logic       rsp_valid,
   input  logic [4:0] rsp_from_x,
   input  logic [4:0] rsp_from_y,
   input  logic [1:0] rsp_carve_dir,
   input  logic       rsp_done_res,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_data,
   output int         error_count,
   output int         pending_count
);
   typedef struct packed {
      logic [4:0] from_x;
      logic [4:0] from_y;
      logic [1:0] carve_dir;
      logic       done_res;
   } carve_t;

   carve_t     carve_q[$];
   bit         seen_map[CELL_TOTAL];
   bit [9:0]   path_stack[CELL_TOTAL];
   int         path_depth;
   int         cur_x;
   int         cur_y;
   int         cells_seen;
   bit         maze_done;
   logic [5:0] rows_reg;
   logic [5:0] cols_reg;

   assign pending_count = carve_q.size();

   function automatic int clamp_size(input logic [5:0] v, input int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit cell_open(input int x, input int y, input logic [1:0] d,
                                    input int rows, input int cols,
                                    output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
         DIR_RIGHT: nx = x + 1;
         DIR_UP:    ny = y + 1;
         DIR_LEFT: begin
            if (x == 0) return 0;
            nx = x - 1;
         end
         default: begin
            if (y == 0) return 0;
            ny = y - 1;
         end
      endcase
      if (nx >= cols || ny >= rows) return 0;
      return !seen_map[ny * MAX_COLS + nx];
   endfunction

   function automatic bit any_cell_open(input int x, input int y, input int rows,
                                        input int cols);
      int nx;
      int ny;
      for (int d = 0; d < 4; d++)
         if (cell_open(x, y, 2'(d), rows, cols, nx, ny)) return 1;
      return 0;
   endfunction

   function automatic bit carve_step(input bit new_maze, input logic [1:0] d,
                                     output carve_t ev);
      int rows;
      int cols;
      int nx;
      int ny;
      rows = clamp_size(rows_reg, MAX_ROWS);
      cols = clamp_size(cols_reg, MAX_COLS);
      ev = '0;
      if (new_maze) begin
         foreach (seen_map[i]) seen_map[i] = 0;
         seen_map[0] = 1;
         path_stack[0] = '0;
         path_depth = 1;
         cur_x = 0;
         cur_y = 0;
         cells_seen = 1;
         maze_done = 0;
         return 0;
      end
      if (cells_seen == 0 || maze_done) return 0;
      if (cells_seen >= rows * cols) begin
         maze_done = 1;
         return 0;
      end
      while (!any_cell_open(cur_x, cur_y, rows, cols)) begin
         if (path_depth == 0) return 0;
         path_depth--;
         if (path_depth == 0) return 0;
         cur_x = path_stack[path_depth - 1] % MAX_COLS;
         cur_y = path_stack[path_depth - 1] / MAX_COLS;
      end
      if (!cell_open(cur_x, cur_y, d, rows, cols, nx, ny)) return 0;
      ev.from_x = 5'(cur_x);
      ev.from_y = 5'(cur_y);
      ev.carve_dir = d;
      seen_map[ny * MAX_COLS + nx] = 1;
      if (path_depth < CELL_TOTAL) begin
         path_stack[path_depth] = 10'(ny * MAX_COLS + nx);
         path_depth++;
      end
      cur_x = nx;
      cur_y = ny;
      cells_seen++;
      if (cells_seen >= rows * cols) maze_done = 1;
      ev.done_res = maze_done;
      return 1;
   endfunction

   always @(posedge clock) begin
      carve_t ev;
      carve_t want;
      if (reset) begin
         carve_q.delete();
         foreach (seen_map[i]) seen_map[i] = 0;
         path_depth = 0;
         cur_x = 0;
         cur_y = 0;
         cells_seen = 0;
         maze_done = 0;
         rows_reg = 6'd8;
         cols_reg = 6'd8;
         error_count = 0;
      end else begin
         if (rsp_valid) begin
            ev = '{rsp_from_x, rsp_from_y, rsp_carve_dir, rsp_done_res};
            if (carve_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected carve x=%0d y=%0d dir=%0d done=%0d", $time,
                           ev.from_x, ev.from_y, ev.carve_dir, ev.done_res);
            end else begin
               want = carve_q.pop_front();
               if (ev != want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: carve mismatch exp x=%0d y=%0d dir=%0d done=%0d, got x=%0d y=%0d dir=%0d done=%0d",
                              $time, want.from_x, want.from_y, want.carve_dir,
                              want.done_res, ev.from_x, ev.from_y, ev.carve_dir,
                              ev.done_res);
               end
            end
         end
         if (start && !busy)
            if (carve_step(req_start_req, req_rand_dir, ev)) carve_q.push_back(ev);
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROWS) rows_reg = csr_data;
            else if (csr_index == REG_COLS) cols_reg = csr_data;
         end
      end
   end
endmodule

/* tb/sv/tb_grid_maze_dfs_generator.sv */
// Testbench top for grid_maze_dfs_generator: clock, reset, request and CSR
// stimulus over several idle phases, and the verdict.
// Depends on gmd_pkg, the generator RTL and grid_maze_dfs_checker.
`timescale 1ns / 100ps
module tb_grid_maze_dfs_generator;
   import gmd_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_start_req;
   logic [1:0] req_rand_dir;
   logic       rsp_valid;
   logic [4:0] rsp_from_x;
   logic [4:0] rsp_from_y;
   logic [1:0] rsp_carve_dir;
   logic       rsp_done_res;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [5:0] csr_data;
   int         error_count;
   int         pending_count;
   int         gap_pct;
   int         cycle_count;

   grid_maze_dfs_generator DUT (.*);
   grid_maze_dfs_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_req(input bit new_maze, input logic [1:0] d);
      start <= 1'b1;
      req_start_req <= new_maze;
      req_rand_dir <= d;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [5:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input logic [5:0] rows, input logic [5:0] cols);
      drain();
      csr_write(REG_ROWS, rows);
      csr_write(REG_COLS, cols);
   endtask

   task automatic run_dirs(input int n);
      repeat (n) send_req(1'b0, 2'($urandom_range(3)));
   endtask

   initial begin
      int sent;
      int n;
      logic [5:0] r;
      logic [5:0] c;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_start_req = 1'b0;
      req_rand_dir = DIR_RIGHT;
      csr_valid = 1'b0;
      csr_index = REG_ROWS;
      csr_data = '0;
      gap_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored before any start, smallest grid to done and past it
      send_req(1'b0, DIR_RIGHT);
      send_req(1'b0, DIR_DOWN);
      set_grid(6'd2, 6'd2);
      send_req(1'b1, DIR_UP);
      send_req(1'b0, DIR_LEFT);
      send_req(1'b0, DIR_DOWN);
      send_req(1'b0, DIR_RIGHT);
      send_req(1'b0, DIR_UP);
      send_req(1'b0, DIR_LEFT);
      send_req(1'b0, DIR_DOWN);
      send_req(1'b0, DIR_RIGHT);
      set_grid(6'd0, 6'd1);
      send_req(1'b1, DIR_RIGHT);
      send_req(1'b0, DIR_UP);
      set_grid(6'd63, 6'd33);
      send_req(1'b1, DIR_RIGHT);
      send_req(1'b0, DIR_UP);
      send_req(1'b0, DIR_RIGHT);
      set_grid(6'd4, 6'd4);
      send_req(1'b1, DIR_DOWN);
      run_dirs(6);
      set_grid(6'd2, 6'd2);
      send_req(1'b0, DIR_UP);
      send_req(1'b0, DIR_RIGHT);

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: gap_pct = 0;
            1: gap_pct = 60;
            2: gap_pct = 6;
            default: gap_pct = 60;
         endcase
         while (sent < (phase + 1) * 170) begin
            case ($urandom_range(9))
               0: begin r = 6'($urandom_range(63)); c = 6'($urandom_range(63)); end
               1: begin r = 6'd32; c = 6'($urandom_range(2, 32)); end
               default: begin
                  r = 6'($urandom_range(2, 6));
                  c = 6'($urandom_range(2, 6));
               end
            endcase
            set_grid(r, c);
            send_req(1'b1, 2'($urandom_range(3)));
            n = $urandom_range(5, 50);
            run_dirs(n);
            sent += n + 1;
            if ($urandom_range(9) == 0) begin
               set_grid(6'($urandom_range(2, 8)), 6'($urandom_range(2, 8)));
               run_dirs(10);
               sent += 10;
            end
            if ($urandom_range(9) == 0) begin
               send_req(1'b1, 2'($urandom_range(3)));
               run_dirs(10);
               sent += 11;
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* grid_maze_dfs_generator.f */
rtl/gmd_pkg.sv
rtl/gmd_visit_map.sv
rtl/grid_maze_dfs_generator.sv
tb/sv/grid_maze_dfs_checker.sv
tb/sv/tb_grid_maze_dfs_generator.sv
